// File: sv/bpnm_pkg.sv
// ----------------------------------------------------------------------------
// bpnm_pkg
// Shared types and constants of the binary PNM stream decoder.
// ----------------------------------------------------------------------------
package bpnm_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int NUM_W         = FRACTION_BITS + 9;
    localparam int STEP_W        = $clog2(FRACTION_BITS);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_HEADER    = 3'd2;
    localparam logic [2:0] ERR_MAXVAL    = 3'd3;
    localparam logic [2:0] ERR_SEPARATOR = 3'd4;
    localparam logic [2:0] ERR_ZERO_DIM  = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  err;
        logic [31:0] width;
        logic [31:0] height;
        logic        gray;
        logic [7:0]  max_sample;
        logic [7:0]  s0;
        logic [7:0]  s1;
        logic [7:0]  s2;
        logic        fin;
    } item_t;

endpackage

// File: sv/bpnm_front.sv
// ----------------------------------------------------------------------------
// bpnm_front
// Byte parser: checks the magic, reads the header numbers and gathers raster
// samples into header, pixel and error records.
// ----------------------------------------------------------------------------
module bpnm_front
    import bpnm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        push,
    output item_t       push_item
);

    localparam logic [2:0] PH_MAGIC0 = 3'd0;
    localparam logic [2:0] PH_MAGIC1 = 3'd1;
    localparam logic [2:0] PH_WIDTH  = 3'd2;
    localparam logic [2:0] PH_HEIGHT = 3'd3;
    localparam logic [2:0] PH_MAXVAL = 3'd4;
    localparam logic [2:0] PH_RASTER = 3'd5;
    localparam logic [2:0] PH_IDLE   = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic        comment_reg, comment_next;
    logic        digits_reg, digits_next;
    logic [31:0] acc_reg, acc_next;
    logic        gray_reg, gray_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [7:0]  max_reg, max_next;
    logic [1:0]  ch_reg, ch_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic [31:0] col_reg, col_next;
    logic [31:0] row_reg, row_next;

    logic        emit;
    logic [1:0]  e_kind;
    logic [2:0]  e_err;
    logic        e_fin;

    always_comb
    begin
        logic [2:0]  ph;
        logic        blank;
        logic        digit;
        logic [3:0]  dv;
        logic [35:0] prod;
        logic        fail;
        logic [2:0]  code;
        logic        fin;

        ph           = first_byte ? PH_MAGIC0 : phase_reg;
        comment_next = first_byte ? 1'b0 : comment_reg;
        digits_next  = first_byte ? 1'b0 : digits_reg;
        acc_next     = first_byte ? 32'd0 : acc_reg;
        gray_next    = first_byte ? 1'b0 : gray_reg;
        width_next   = first_byte ? 32'd0 : width_reg;
        height_next  = first_byte ? 32'd0 : height_reg;
        max_next     = first_byte ? 8'd0 : max_reg;
        ch_next      = first_byte ? 2'd0 : ch_reg;
        red_next     = first_byte ? 8'd0 : red_reg;
        green_next   = first_byte ? 8'd0 : green_reg;
        col_next     = first_byte ? 32'd0 : col_reg;
        row_next     = first_byte ? 32'd0 : row_reg;
        phase_next   = ph;

        blank = (data_byte == 8'h20) || (data_byte == 8'h0A) || (data_byte == 8'h0D) ||
                (data_byte == 8'h09) || (data_byte == 8'h0C) || (data_byte == 8'h0B);
        digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
        dv    = 4'(data_byte - 8'h30);
        prod  = {1'b0, acc_next, 3'b000} + {3'b000, acc_next, 1'b0} + 36'(dv);
        fail  = 1'b0;
        code  = ERR_NONE;
        fin   = (col_next == width_next - 32'd1) && (row_next == height_next - 32'd1);
        emit  = 1'b0;
        e_kind = KIND_ERROR;
        e_fin  = 1'b0;

        unique case (ph)
            PH_MAGIC0:
            begin
                if (data_byte != 8'h50 || last_byte)
                begin
                    fail = 1'b1;
                    code = ERR_MAGIC;
                end
                else
                begin
                    phase_next = PH_MAGIC1;
                end
            end
            PH_MAGIC1:
            begin
                if ((data_byte != 8'h35 && data_byte != 8'h36) || last_byte)
                begin
                    fail = 1'b1;
                    code = ERR_MAGIC;
                end
                else
                begin
                    gray_next  = (data_byte == 8'h35);
                    phase_next = PH_WIDTH;
                end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL:
            begin
                if (comment_next)
                begin
                    if (data_byte == 8'h0A)
                    begin
                        comment_next = 1'b0;
                    end
                    if (last_byte)
                    begin
                        fail = 1'b1;
                        code = ERR_HEADER;
                    end
                end
                else if (digits_next && digit)
                begin
                    if (prod[35:32] != 4'd0)
                    begin
                        fail = 1'b1;
                        code = ERR_HEADER;
                    end
                    else
                    begin
                        acc_next = prod[31:0];
                        if (last_byte)
                        begin
                            fail = 1'b1;
                            if (ph != PH_MAXVAL)
                            begin
                                code = ERR_HEADER;
                            end
                            else if (prod[31:0] == 32'd0 || prod[31:0] > 32'd255)
                            begin
                                code = ERR_MAXVAL;
                            end
                            else
                            begin
                                code = ERR_SEPARATOR;
                            end
                        end
                    end
                end
                else if (digits_next && ph == PH_MAXVAL)
                begin
                    fail = 1'b1;
                    if (acc_next == 32'd0 || acc_next > 32'd255)
                    begin
                        code = ERR_MAXVAL;
                    end
                    else if (!blank)
                    begin
                        code = ERR_SEPARATOR;
                    end
                    else if (width_next == 32'd0 || height_next == 32'd0)
                    begin
                        code = ERR_ZERO_DIM;
                    end
                    else
                    begin
                        max_next   = acc_next[7:0];
                        col_next   = 32'd0;
                        row_next   = 32'd0;
                        ch_next    = 2'd0;
                        phase_next = PH_RASTER;
                        if (last_byte)
                        begin
                            code = ERR_TRUNCATED;
                        end
                        else
                        begin
                            fail   = 1'b0;
                            emit   = 1'b1;
                            e_kind = KIND_HEADER;
                        end
                    end
                end
                else
                begin
                    if (digits_next)
                    begin
                        if (ph == PH_WIDTH)
                        begin
                            width_next = acc_next;
                        end
                        else
                        begin
                            height_next = acc_next;
                        end
                        phase_next  = ph + 3'd1;
                        digits_next = 1'b0;
                        acc_next    = 32'd0;
                    end
                    if (blank)
                    begin
                    end
                    else if (data_byte == 8'h23)
                    begin
                        comment_next = 1'b1;
                    end
                    else if (digit)
                    begin
                        digits_next = 1'b1;
                        acc_next    = 32'(dv);
                    end
                    else
                    begin
                        fail = 1'b1;
                        code = ERR_HEADER;
                    end
                    if (!fail && last_byte)
                    begin
                        fail = 1'b1;
                        code = ERR_HEADER;
                    end
                end
            end
            PH_RASTER:
            begin
                if (!gray_next && ch_next == 2'd0)
                begin
                    red_next = data_byte;
                    ch_next  = 2'd1;
                    if (last_byte)
                    begin
                        fail = 1'b1;
                        code = ERR_TRUNCATED;
                    end
                end
                else if (!gray_next && ch_next == 2'd1)
                begin
                    green_next = data_byte;
                    ch_next    = 2'd2;
                    if (last_byte)
                    begin
                        fail = 1'b1;
                        code = ERR_TRUNCATED;
                    end
                end
                else
                begin
                    ch_next = 2'd0;
                    if (col_next == width_next - 32'd1)
                    begin
                        col_next = 32'd0;
                        row_next = row_next + 32'd1;
                    end
                    else
                    begin
                        col_next = col_next + 32'd1;
                    end
                    if (fin)
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        e_kind     = KIND_PIXEL;
                        e_fin      = 1'b1;
                    end
                    else if (last_byte)
                    begin
                        fail = 1'b1;
                        code = ERR_TRUNCATED;
                    end
                    else
                    begin
                        emit   = 1'b1;
                        e_kind = KIND_PIXEL;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (fail)
        begin
            phase_next = PH_IDLE;
            emit       = 1'b1;
            e_kind     = KIND_ERROR;
            e_fin      = 1'b0;
        end
        e_err = fail ? code : ERR_NONE;
    end

    assign push = take && emit;

    always_comb
    begin
        push_item.kind       = e_kind;
        push_item.err        = e_err;
        push_item.width      = width_next;
        push_item.height     = height_next;
        push_item.gray       = gray_next;
        push_item.max_sample = max_next;
        push_item.s0         = gray_next ? data_byte : red_next;
        push_item.s1         = green_next;
        push_item.s2         = data_byte;
        push_item.fin        = e_fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC0;
            comment_reg <= 1'b0;
            digits_reg  <= 1'b0;
            acc_reg     <= 32'd0;
            gray_reg    <= 1'b0;
            width_reg   <= 32'd0;
            height_reg  <= 32'd0;
            max_reg     <= 8'd0;
            ch_reg      <= 2'd0;
            red_reg     <= 8'd0;
            green_reg   <= 8'd0;
            col_reg     <= 32'd0;
            row_reg     <= 32'd0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            comment_reg <= comment_next;
            digits_reg  <= digits_next;
            acc_reg     <= acc_next;
            gray_reg    <= gray_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            max_reg     <= max_next;
            ch_reg      <= ch_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

endmodule

// File: sv/bpnm_queue.sv
// ----------------------------------------------------------------------------
// bpnm_queue
// Short first-in first-out queue of parsed records between parser and scaler.
// ----------------------------------------------------------------------------
module bpnm_queue
    import bpnm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t pop_item,
    output logic  full,
    output logic  empty
);

    item_t               mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_reg;
    logic [QPTR_W-1:0]   rd_reg;
    logic [QPTR_W:0]     count_reg;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

endmodule

// File: sv/bpnm_back.sv
// ----------------------------------------------------------------------------
// bpnm_back
// Scaler and output stage: turns each sample into a fixed-point fraction of
// maxval with a shared shift-subtract divider and holds the result register.
// ----------------------------------------------------------------------------
module bpnm_back
    import bpnm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     empty,
    input  item_t                    pop_item,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               kind,
    output logic [31:0]              width,
    output logic [31:0]              height,
    output logic                     gray,
    output logic [7:0]               max_sample,
    output logic [15:0]              red,
    output logic [15:0]              green,
    output logic [15:0]              blue,
    output logic                     over_range,
    output logic                     last_pixel,
    output logic [2:0]               error_code
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [FRACTION_BITS-1:0] FULL = '1;

    logic [1:0]               state_reg, state_next;
    item_t                    item_reg;
    logic [1:0]               ch_reg, ch_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [9:0]               rem_reg, rem_next;
    logic [FRACTION_BITS-1:0] num_reg, num_next;
    logic [FRACTION_BITS-1:0] q_reg, q_next;
    logic [FRACTION_BITS-1:0] res_reg [3];
    logic [FRACTION_BITS-1:0] res_next [3];
    logic                     ovr_reg, ovr_next;
    logic                     out_valid_reg;
    logic                     load_out;

    logic [7:0]               s;
    logic [NUM_W-1:0]         n_full;
    logic [9:0]               divisor;
    logic [9:0]               trial;
    logic                     ge;
    logic                     last_ch;

    always_comb
    begin
        case (ch_reg)
            2'd0:    s = item_reg.s0;
            2'd1:    s = item_reg.s1;
            default: s = item_reg.s2;
        endcase
    end

    assign n_full  = {s, {(FRACTION_BITS + 1){1'b0}}} - NUM_W'({s, 1'b0})
                     + NUM_W'(item_reg.max_sample);
    assign divisor = {1'b0, item_reg.max_sample, 1'b0};
    assign trial   = {rem_reg[8:0], num_reg[FRACTION_BITS-1]};
    assign ge      = (trial >= divisor);
    assign last_ch = item_reg.gray || (ch_reg == 2'd2);
    assign pop     = (state_reg == ST_IDLE) && !empty;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        step_next   = step_reg;
        rem_next    = rem_reg;
        num_next    = num_reg;
        q_next      = q_reg;
        ovr_next    = ovr_reg;
        res_next[0] = res_reg[0];
        res_next[1] = res_reg[1];
        res_next[2] = res_reg[2];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    ch_next     = 2'd0;
                    ovr_next    = 1'b0;
                    res_next[0] = '0;
                    res_next[1] = '0;
                    res_next[2] = '0;
                    state_next  = (pop_item.kind == KIND_PIXEL) ? ST_LOAD : ST_DONE;
                end
            end
            ST_LOAD:
            begin
                if (s > item_reg.max_sample)
                begin
                    ovr_next         = 1'b1;
                    res_next[ch_reg] = FULL;
                    if (last_ch)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ch_next = ch_reg + 2'd1;
                    end
                end
                else
                begin
                    rem_next   = {1'b0, n_full[NUM_W-1:FRACTION_BITS]};
                    num_next   = n_full[FRACTION_BITS-1:0];
                    step_next  = '0;
                    q_next     = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = ge ? (trial - divisor) : trial;
                num_next  = {num_reg[FRACTION_BITS-2:0], 1'b0};
                q_next    = {q_reg[FRACTION_BITS-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(FRACTION_BITS - 1))
                begin
                    res_next[ch_reg] = q_next;
                    if (last_ch)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= load_out || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= pop_item;
        end
        ch_reg     <= ch_next;
        step_reg   <= step_next;
        rem_reg    <= rem_next;
        num_reg    <= num_next;
        q_reg      <= q_next;
        ovr_reg    <= ovr_next;
        res_reg[0] <= res_next[0];
        res_reg[1] <= res_next[1];
        res_reg[2] <= res_next[2];
        if (load_out)
        begin
            kind       <= item_reg.kind;
            width      <= item_reg.width;
            height     <= item_reg.height;
            gray       <= item_reg.gray;
            max_sample <= item_reg.max_sample;
            red        <= 16'(res_reg[0]);
            green      <= 16'(item_reg.gray ? res_reg[0] : res_reg[1]);
            blue       <= 16'(item_reg.gray ? res_reg[0] : res_reg[2]);
            over_range <= ovr_reg;
            last_pixel <= item_reg.fin;
            error_code <= item_reg.err;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sv/binary_pnm_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// binary_pnm_stream_decoder_core
// Decodes a binary P5/P6 file, one byte per transfer, into a header record,
// one scaled pixel per sample or triple, and error records.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | in_valid, in_stall, data_byte,           | byte stream in
//          | first_byte, last_byte                    |
//  out     | out_valid, out_stall, kind, width, ...   | result stream out
//
// The parser takes one byte per cycle while the record queue has room.
// Each pixel channel is loaded in turn and, unless it exceeds maxval, run
// through the shift-subtract divider in the scaler; header and error
// records skip the divider. A stalled output holds its record, and the queue
// then fills and stalls the input. Reset is asynchronous and clears the
// parser, queue and scaler control.
// ----------------------------------------------------------------------------
module binary_pnm_stream_decoder_core
    import bpnm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [31:0] width,
    output logic [31:0] height,
    output logic        gray,
    output logic [7:0]  max_sample,
    output logic [15:0] red,
    output logic [15:0] green,
    output logic [15:0] blue,
    output logic        over_range,
    output logic        last_pixel,
    output logic [2:0]  error_code
);

    logic  take;
    logic  push;
    item_t push_item;
    logic  pop;
    item_t pop_item;
    logic  full;
    logic  empty;

    assign in_stall = full;
    assign take     = in_valid && !full;

    bpnm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .push       (push),
        .push_item  (push_item)
    );

    bpnm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (full),
        .empty     (empty)
    );

    bpnm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .pop_item   (pop_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .width      (width),
        .height     (height),
        .gray       (gray),
        .max_sample (max_sample),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .over_range (over_range),
        .last_pixel (last_pixel),
        .error_code (error_code)
    );

endmodule

// File: sv/bpnm_checker.sv
// ----------------------------------------------------------------------------
// bpnm_checker
// Port-level checks of the decoder's result stream.
// ----------------------------------------------------------------------------
module bpnm_checker
    import bpnm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [15:0] red,
    input logic        over_range,
    input logic        last_pixel,
    input logic [2:0]  error_code
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(error_code))
        else $error("result changed while stalled");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
        else $error("error code does not match result kind");

    a_pix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_PIXEL |-> !over_range && !last_pixel && red == 16'd0)
        else $error("pixel fields set on a non-pixel result");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind != 2'd3)
        else $error("undefined result kind");

endmodule

bind binary_pnm_stream_decoder_core bpnm_checker u_bpnm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .red        (red),
    .over_range (over_range),
    .last_pixel (last_pixel),
    .error_code (error_code)
);

// File: test/binary_pnm_stream_decoder_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_pnm_stream_decoder_core_test
// Self-checking testbench of the binary PNM stream decoder. Directed and
// random P5/P6 files, well formed and broken, are sent one byte per transfer
// under random idling on both sides, bar one test. Expected records are computed
// by a behavioral model of the parser and compared in order with every output.
// ----------------------------------------------------------------------------
module binary_pnm_stream_decoder_core_test;
    import bpnm_pkg::*;

    localparam int HOLD_CYCLES = 300;

    typedef enum int
    {
        PH_MAGIC0,
        PH_MAGIC1,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_RASTER,
        PH_IDLE
    } phase_t;

    typedef struct
    {
        logic [1:0]  kind;
        logic [31:0] width;
        logic [31:0] height;
        logic        gray;
        logic [7:0]  max_sample;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        over_range;
        logic        last_pixel;
        logic [2:0]  error_code;
    } record_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [31:0] width;
    logic [31:0] height;
    logic        gray;
    logic [7:0]  max_sample;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        over_range;
    logic        last_pixel;
    logic [2:0]  error_code;

    record_t     expected_records[$];
    int          error_count;
    int          record_count;
    int          byte_count;
    int          file_count;
    int          idle_cycles = 0;
    int          hold_count = 0;
    int          stall_left = 0;
    bit          idling_on;
    bit          hold_output;

    phase_t      phase;
    bit          in_comment;
    bit          digits_seen;
    logic [31:0] accum;
    bit          is_gray;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [7:0]  smax;
    int          chan;
    logic [7:0]  held_r;
    logic [7:0]  held_g;
    logic [63:0] pix_left;

    byte unsigned file_bytes[$];

    binary_pnm_stream_decoder_core u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .width      (width),
        .height     (height),
        .gray       (gray),
        .max_sample (max_sample),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .over_range (over_range),
        .last_pixel (last_pixel),
        .error_code (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h0a || c == 8'h0d || c == 8'h09 || c == 8'h0c
            || c == 8'h0b;
    endfunction

    function automatic logic [15:0] scale_sample(input logic [7:0] s, inout bit ovr);
        logic [63:0] full;
        full = (64'd1 << FRACTION_BITS) - 1;
        if (smax == 0)
            return 16'd0;
        if (s > smax)
        begin
            ovr = 1'b1;
            return full[15:0];
        end
        return 16'((64'(s) * full * 2 + 64'(smax)) / (2 * 64'(smax)));
    endfunction

    task automatic clear_parser();
        phase = PH_MAGIC0;
        in_comment = 0;
        digits_seen = 0;
        accum = 0;
        is_gray = 0;
        img_w = 0;
        img_h = 0;
        smax = 0;
        chan = 0;
        held_r = 0;
        held_g = 0;
        pix_left = 0;
    endtask

    task automatic push_record(input logic [1:0] k, input logic [15:0] r,
                               input logic [15:0] g, input logic [15:0] b,
                               input bit ovr, input bit fin, input logic [2:0] code);
        record_t rec;
        rec.kind = k;
        rec.width = img_w;
        rec.height = img_h;
        rec.gray = is_gray;
        rec.max_sample = smax;
        rec.red = r;
        rec.green = g;
        rec.blue = b;
        rec.over_range = ovr;
        rec.last_pixel = fin;
        rec.error_code = code;
        expected_records.push_back(rec);
    endtask

    task automatic push_error(input logic [2:0] code);
        phase = PH_IDLE;
        push_record(KIND_ERROR, '0, '0, '0, 1'b0, 1'b0, code);
    endtask

    task automatic decode_byte(input logic [7:0] b, input bit first, input bit last);
        bit          digit;
        bit          ovr;
        logic [63:0] nxt;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] bl;
        bit          fin;
        if (first)
            clear_parser();
        case (phase)
            PH_MAGIC0:
            begin
                if (b != "P" || last)
                    push_error(ERR_MAGIC);
                else
                    phase = PH_MAGIC1;
            end
            PH_MAGIC1:
            begin
                if ((b != "5" && b != "6") || last)
                    push_error(ERR_MAGIC);
                else
                begin
                    is_gray = (b == "5");
                    phase = PH_WIDTH;
                end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL:
            begin
                if (in_comment)
                begin
                    if (b == 8'h0a)
                        in_comment = 0;
                end
                else
                begin
                    digit = (b >= "0" && b <= "9");
                    if (digits_seen && digit)
                    begin
                        nxt = 64'(accum) * 10 + 64'(b - "0");
                        if (nxt > 64'hFFFF_FFFF)
                            push_error(ERR_HEADER);
                        else
                        begin
                            accum = nxt[31:0];
                            if (last)
                            begin
                                if (phase != PH_MAXVAL)
                                    push_error(ERR_HEADER);
                                else if (accum == 0 || accum > 255)
                                    push_error(ERR_MAXVAL);
                                else
                                    push_error(ERR_SEPARATOR);
                            end
                        end
                        return;
                    end
                    if (digits_seen && phase == PH_MAXVAL)
                    begin
                        if (accum == 0 || accum > 255)
                            push_error(ERR_MAXVAL);
                        else if (!is_blank(b))
                            push_error(ERR_SEPARATOR);
                        else if (img_w == 0 || img_h == 0)
                            push_error(ERR_ZERO_DIM);
                        else
                        begin
                            smax = accum[7:0];
                            pix_left = 64'(img_w) * 64'(img_h);
                            chan = 0;
                            phase = PH_RASTER;
                            if (last)
                                push_error(ERR_TRUNCATED);
                            else
                                push_record(KIND_HEADER, '0, '0, '0, 1'b0, 1'b0, ERR_NONE);
                        end
                        return;
                    end
                    if (digits_seen)
                    begin
                        if (phase == PH_WIDTH)
                        begin
                            img_w = accum;
                            phase = PH_HEIGHT;
                        end
                        else
                        begin
                            img_h = accum;
                            phase = PH_MAXVAL;
                        end
                        digits_seen = 0;
                        accum = 0;
                        digit = 0;
                    end
                    if (is_blank(b))
                    begin
                    end
                    else if (b == "#")
                        in_comment = 1;
                    else if (digit)
                    begin
                        digits_seen = 1;
                        accum = 32'(b - "0");
                    end
                    else
                    begin
                        push_error(ERR_HEADER);
                        return;
                    end
                end
                if (last)
                    push_error(ERR_HEADER);
            end
            PH_RASTER:
            begin
                ovr = 0;
                if (!is_gray && chan == 0)
                begin
                    held_r = b;
                    chan = 1;
                    if (last)
                        push_error(ERR_TRUNCATED);
                    return;
                end
                if (!is_gray && chan == 1)
                begin
                    held_g = b;
                    chan = 2;
                    if (last)
                        push_error(ERR_TRUNCATED);
                    return;
                end
                if (is_gray)
                begin
                    r = scale_sample(b, ovr);
                    g = r;
                    bl = r;
                end
                else
                begin
                    r = scale_sample(held_r, ovr);
                    g = scale_sample(held_g, ovr);
                    bl = scale_sample(b, ovr);
                end
                chan = 0;
                if (pix_left > 0)
                    pix_left--;
                fin = (pix_left == 0);
                if (fin)
                    phase = PH_IDLE;
                else if (last)
                begin
                    push_error(ERR_TRUNCATED);
                    return;
                end
                push_record(KIND_PIXEL, r, g, bl, ovr, fin, ERR_NONE);
            end
            default:
                phase = PH_IDLE;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        first_byte <= first;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b, first, last);
        byte_count++;
        @(negedge clk);
    endtask

    task automatic send_file(input bit cut);
        int n;
        n = file_bytes.size();
        file_count++;
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == 0, cut && i == n - 1);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            file_bytes.push_back(s[i]);
    endtask

    task automatic build_image(input bit gray_file, input int w, input int h,
                               input int maxv, input bit fancy);
        int samples;
        file_bytes.delete();
        add_text(gray_file ? "P5" : "P6");
        if (fancy)
            add_text(" #c\n\t");
        else
            add_text(" ");
        add_text($sformatf("%0d\n%0d", w, h));
        if (fancy)
            add_text("\r#x y\n ");
        else
            add_text(" ");
        add_text($sformatf("%0d\n", maxv));
        samples = w * h * (gray_file ? 1 : 3);
        for (int i = 0; i < samples; i++)
            file_bytes.push_back($urandom_range(0, 7) == 0 ? 8'($urandom_range(0, 255))
                                                           : 8'($urandom_range(0, maxv)));
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_records.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (120) @(negedge clk);
    endtask

    task automatic test_directed();
        build_image(1'b1, 2, 2, 255, 1'b0);
        file_bytes[file_bytes.size() - 4] = 8'd0;
        file_bytes[file_bytes.size() - 1] = 8'd255;
        send_file(1'b0);
        build_image(1'b0, 1, 1, 1, 1'b1);
        file_bytes.push_back(8'h41);
        send_file(1'b0);
        build_image(1'b1, 1, 1, 3, 1'b0);
        file_bytes[file_bytes.size() - 1] = 8'd200;
        send_file(1'b0);
        file_bytes = '{8'h51, 8'h35};
        send_file(1'b0);
        file_bytes = '{8'h50, 8'h37};
        send_file(1'b0);
        file_bytes = '{8'h50};
        send_file(1'b1);
        file_bytes.delete();
        add_text("P5 4294967296 1 9\n");
        send_file(1'b0);
        file_bytes.delete();
        add_text("P6 2 x");
        send_file(1'b0);
        file_bytes.delete();
        add_text("P5 2 2 256\n");
        send_file(1'b0);
        file_bytes.delete();
        add_text("P5 2 2 0 ");
        send_file(1'b0);
        file_bytes.delete();
        add_text("P5 2 2 9x");
        send_file(1'b0);
        file_bytes.delete();
        add_text("P5 0 2 9\n");
        send_file(1'b0);
        file_bytes.delete();
        add_text("P5 3 2 25");
        send_file(1'b1);
        build_image(1'b0, 2, 1, 100, 1'b0);
        send_file(1'b1);
        wait_drain();
    endtask

    task automatic test_random_files();
        int kind_sel;
        int cut_at;
        while (byte_count < 1000)
        begin
            kind_sel = $urandom_range(0, 9);
            build_image(1'($urandom_range(0, 1)), $urandom_range(1, 4), $urandom_range(1, 3),
                        $urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 255),
                        1'($urandom_range(0, 1)));
            if (kind_sel == 0)
            begin
                cut_at = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > cut_at)
                    void'(file_bytes.pop_back());
                send_file(1'b1);
            end
            else if (kind_sel == 1)
            begin
                file_bytes[$urandom_range(0, file_bytes.size() - 1)] =
                    8'($urandom_range(0, 255));
                send_file(1'($urandom_range(0, 1)));
            end
            else
            begin
                if (kind_sel == 2)
                    repeat ($urandom_range(1, 4))
                        file_bytes.push_back(8'($urandom_range(0, 255)));
                send_file(1'b0);
            end
        end
        wait_drain();
    endtask

    task automatic test_output_hold();
        hold_output = 1'b1;
        build_image(1'b1, 4, 3, 255, 1'b0);
        send_file(1'b0);
        hold_output = 1'b0;
        wait_drain();
    endtask

    task automatic test_no_idling();
        idling_on = 1'b0;
        repeat (8)
        begin
            build_image(1'($urandom_range(0, 1)), $urandom_range(1, 3), $urandom_range(1, 2),
                        $urandom_range(1, 255), 1'b0);
            send_file(1'b0);
        end
        wait_drain();
    endtask

    always @(negedge clk)
    begin
        if (!hold_output)
            hold_count <= 0;
        else if (hold_count < HOLD_CYCLES)
            hold_count <= hold_count + 1;
        if (hold_output && hold_count < HOLD_CYCLES)
            out_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        record_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            record_count++;
            if (expected_records.size() == 0)
            begin
                $display("%0t: unexpected record kind %0d", $time, kind);
                error_count++;
            end
            else
            begin
                e = expected_records.pop_front();
                if (kind !== e.kind || width !== e.width || height !== e.height
                    || gray !== e.gray || max_sample !== e.max_sample || red !== e.red
                    || green !== e.green || blue !== e.blue
                    || over_range !== e.over_range || last_pixel !== e.last_pixel
                    || error_code !== e.error_code)
                begin
                    $display("%0t: expected k%0d w%0d h%0d g%0d m%0d %h %h %h o%0d l%0d e%0d",
                             $time, e.kind, e.width, e.height, e.gray, e.max_sample,
                             e.red, e.green, e.blue, e.over_range, e.last_pixel,
                             e.error_code);
                    $display("%0t: actual   k%0d w%0d h%0d g%0d m%0d %h %h %h o%0d l%0d e%0d",
                             $time, kind, width, height, gray, max_sample, red, green,
                             blue, over_range, last_pixel, error_code);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'd0;
        first_byte = 1'b0;
        last_byte = 1'b0;
        error_count = 0;
        record_count = 0;
        byte_count = 0;
        file_count = 0;
        idling_on = 1'b1;
        hold_output = 1'b0;
        clear_parser();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_output_hold();
        test_random_files();
        test_no_idling();
        if (expected_records.size() != 0)
        begin
            $display("%0t: %0d expected records never arrived", $time, expected_records.size());
            error_count++;
        end
        $display("Sent %0d bytes in %0d files and checked %0d records.",
                 byte_count, file_count, record_count);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: binary_pnm_stream_decoder_core.f
sv/bpnm_pkg.sv
sv/bpnm_front.sv
sv/bpnm_queue.sv
sv/bpnm_back.sv
sv/binary_pnm_stream_decoder_core.sv
sv/bpnm_checker.sv
test/binary_pnm_stream_decoder_core_test.sv
